/* hdl/bpbc_pkg.sv */
// ---------------------------------------------------------------------------
// Button press blink coder package
// Shared types, field widths and timing constants of the press length coder.
// ---------------------------------------------------------------------------
`default_nettype none

package bpbc_pkg;

   // Pattern selection held in the mode register.
   typedef enum logic [1:0] {
      MODE_BLINK = 2'd0,
      MODE_LEVEL = 2'd1,
      MODE_VALUE = 2'd2,
      MODE_MULTI = 2'd3
   } mode_type;

   localparam int DUR_W    = 16;
   localparam int VALUE_W  = 10;
   localparam int PULSES_W = 8;
   localparam int HALF_W   = 9;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Bit positions of the result fields inside rsp_tdata.
   localparam int RSP_LED_BIT  = 0;
   localparam int RSP_DUR_LSB  = 1;
   localparam int RSP_VAL_LSB  = RSP_DUR_LSB + DUR_W;
   localparam int RSP_BUSY_BIT = RSP_VAL_LSB + VALUE_W;
   localparam int RSP_USED_W   = RSP_BUSY_BIT + 1;

   localparam logic [DUR_W-1:0]   DUR_MAX      = 16'hFFFF;
   localparam logic [DUR_W-1:0]   DUR_1000     = 16'd1000;
   localparam logic [DUR_W-1:0]   DUR_3000     = 16'd3000;
   localparam logic [VALUE_W-1:0] VALUE_MAX    = 10'd655;

   localparam logic [HALF_W-1:0]  HALF_BLINK   = 9'd250;
   localparam logic [HALF_W-1:0]  HALF_SINGLE  = 9'd300;
   localparam logic [HALF_W-1:0]  HALF_TRIPLE  = 9'd150;
   localparam logic [HALF_W-1:0]  HALF_DOUBLE  = 9'd200;
   localparam logic [HALF_W-1:0]  HALF_SHORT   = 9'd100;

   localparam logic [PULSES_W-1:0] PULSES_ONE   = 8'd1;
   localparam logic [PULSES_W-1:0] PULSES_TWO   = 8'd2;
   localparam logic [PULSES_W-1:0] PULSES_THREE = 8'd3;
   localparam logic [PULSES_W-1:0] PULSES_FIVE  = 8'd5;

   // Reciprocals for division of the quartered duration by 125 and by 25.
   localparam logic [14:0] RECIP_125 = 15'd16778;
   localparam int          SHIFT_125 = 21;
   localparam logic [12:0] RECIP_25  = 13'd5243;
   localparam int          SHIFT_25  = 17;

endpackage

`default_nettype wire

/* hdl/button_press_blink_coder_top.sv */
// ---------------------------------------------------------------------------
// Button press blink coder, top level
// Measures button press lengths on 1 ms ticks and plays an LED pattern or stores a value.
// ---------------------------------------------------------------------------
// Each request item is one 1 ms tick carrying the active-low button level in
// req_tdata[0]; every item gives exactly one response item holding the LED
// level and status after that tick. A new item is accepted every cycle while
// no response is held back: the tick update is a single pass of logic from
// the state registers into the response register, whose longest path is the
// reciprocal multiply that turns the released press length into a pulse
// count or a value. req_tready is low only while a response is held back by
// rsp_tready. The mode register is sampled on the release tick only; the user
// must write it via csr_wen/csr_wdata while the block is idle; it is not enforced.
`default_nettype none

module button_press_blink_coder_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // req_tdata: [0] button_level, [7:1] zero
   input  wire logic [bpbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rsp_tdata: [0] led_on, [16:1] last_duration_ms, [26:17] adjusted_value,
   // [27] pattern_busy, [31:28] zero
   output logic [bpbc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [1:0]                        csr_wdata
);

   localparam int DW = bpbc_pkg::DUR_W;
   localparam int PW = bpbc_pkg::PULSES_W;
   localparam int HW = bpbc_pkg::HALF_W;
   localparam int VW = bpbc_pkg::VALUE_W;

   bpbc_pkg::mode_type   mode_ff;
   logic [COUNT_WIDTH-1:0] press_counter_ff, press_counter_in;
   logic [DW-1:0]        latched_duration_ff, latched_duration_in;
   logic                 prev_button_ff, prev_button_in;
   logic [PW-1:0]        pulses_left_ff, pulses_left_in;
   logic [HW-1:0]        half_period_ff, half_period_in;
   logic [HW-1:0]        phase_timer_ff, phase_timer_in;
   logic                 led_phase_ff, led_phase_in;
   logic [VW-1:0]        stored_value_ff, stored_value_in;
   logic                 single_pulse_ff, single_pulse_in;
   logic                 rsp_tvalid_ff;
   logic [bpbc_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                 req_accept;
   logic                 button_level;
   logic                 busy;
   logic                 count_full;
   logic [DW-1:0]        duration;
   logic [28:0]          prod_500;
   logic [26:0]          prod_100;
   logic [PW-1:0]        blink_pulses;
   logic [HW-1:0]        timer_dec;
   logic [PW-1:0]        pulses_dec;
   logic                 led_out;

   assign req_tready   = !rsp_tvalid_ff || rsp_tready;
   assign req_accept   = req_tvalid && req_tready;
   assign button_level = req_tdata[0];
   assign busy         = pulses_left_ff != '0;
   assign count_full   = press_counter_ff == '1;

   // Saturate the press count to the 16-bit duration field.
   always_comb begin
      if (press_counter_ff > COUNT_WIDTH'(bpbc_pkg::DUR_MAX)) begin
         duration = bpbc_pkg::DUR_MAX;
      end else begin
         duration = DW'(press_counter_ff);
      end
   end

   // d/500 = (d/4)/125 and d/100 = (d/4)/25, each by a reciprocal multiply
   // that is exact over the whole 14-bit range of d/4.
   assign prod_500     = 29'(duration[DW-1:2]) * 29'(bpbc_pkg::RECIP_125);
   assign prod_100     = 27'(duration[DW-1:2]) * 27'(bpbc_pkg::RECIP_25);
   assign blink_pulses = prod_500[bpbc_pkg::SHIFT_125 +: PW];

   assign timer_dec  = (phase_timer_ff != '0) ? phase_timer_ff - 1'b1 : phase_timer_ff;
   assign pulses_dec = pulses_left_ff - 1'b1;

   always_comb begin
      press_counter_in    = press_counter_ff;
      latched_duration_in = latched_duration_ff;
      prev_button_in      = prev_button_ff;
      pulses_left_in      = pulses_left_ff;
      half_period_in      = half_period_ff;
      phase_timer_in      = phase_timer_ff;
      led_phase_in        = led_phase_ff;
      stored_value_in     = stored_value_ff;
      single_pulse_in     = single_pulse_ff;

      if (busy) begin
         // The button is ignored while a pattern plays.
         phase_timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (led_phase_ff) begin
               led_phase_in = 1'b0;
               if (single_pulse_ff && pulses_left_ff == bpbc_pkg::PULSES_ONE) begin
                  pulses_left_in = '0;
               end else begin
                  phase_timer_in = half_period_ff;
               end
            end else begin
               pulses_left_in = pulses_dec;
               if (pulses_dec != '0) begin
                  led_phase_in   = 1'b1;
                  phase_timer_in = half_period_ff;
               end
            end
         end
      end else if (!button_level) begin
         if (prev_button_ff) begin
            press_counter_in = COUNT_WIDTH'(1);
         end else if (!count_full) begin
            press_counter_in = press_counter_ff + 1'b1;
         end
         prev_button_in = 1'b0;
      end else begin
         prev_button_in = 1'b1;
         if (!prev_button_ff) begin
            latched_duration_in = duration;
            unique case (mode_ff)
               bpbc_pkg::MODE_BLINK: begin
                  pulses_left_in  = blink_pulses;
                  half_period_in  = bpbc_pkg::HALF_BLINK;
                  phase_timer_in  = bpbc_pkg::HALF_BLINK;
                  led_phase_in    = blink_pulses != '0;
                  single_pulse_in = 1'b0;
               end
               bpbc_pkg::MODE_LEVEL: begin
                  led_phase_in = 1'b1;
                  if (duration < bpbc_pkg::DUR_1000) begin
                     pulses_left_in  = bpbc_pkg::PULSES_ONE;
                     half_period_in  = bpbc_pkg::HALF_SINGLE;
                     phase_timer_in  = bpbc_pkg::HALF_SINGLE;
                     single_pulse_in = 1'b1;
                  end else begin
                     pulses_left_in  = bpbc_pkg::PULSES_THREE;
                     half_period_in  = bpbc_pkg::HALF_TRIPLE;
                     phase_timer_in  = bpbc_pkg::HALF_TRIPLE;
                     single_pulse_in = 1'b0;
                  end
               end
               bpbc_pkg::MODE_VALUE: begin
                  stored_value_in = prod_100[bpbc_pkg::SHIFT_25 +: VW];
               end
               bpbc_pkg::MODE_MULTI: begin
                  led_phase_in = 1'b1;
                  if (duration < bpbc_pkg::DUR_1000) begin
                     pulses_left_in  = bpbc_pkg::PULSES_ONE;
                     half_period_in  = bpbc_pkg::HALF_SHORT;
                     phase_timer_in  = bpbc_pkg::HALF_SHORT;
                     single_pulse_in = 1'b1;
                  end else if (duration < bpbc_pkg::DUR_3000) begin
                     pulses_left_in  = bpbc_pkg::PULSES_TWO;
                     half_period_in  = bpbc_pkg::HALF_DOUBLE;
                     phase_timer_in  = bpbc_pkg::HALF_DOUBLE;
                     single_pulse_in = 1'b0;
                  end else begin
                     pulses_left_in  = bpbc_pkg::PULSES_FIVE;
                     half_period_in  = bpbc_pkg::HALF_SHORT;
                     phase_timer_in  = bpbc_pkg::HALF_SHORT;
                     single_pulse_in = 1'b0;
                  end
               end
            endcase
         end
      end

      if (!prev_button_in) begin
         led_out = 1'b1;
      end else begin
         led_out = (pulses_left_in != '0) && led_phase_in;
      end

      rsp_tdata_in = '0;
      rsp_tdata_in[bpbc_pkg::RSP_LED_BIT]       = led_out;
      rsp_tdata_in[bpbc_pkg::RSP_DUR_LSB +: DW] = latched_duration_in;
      rsp_tdata_in[bpbc_pkg::RSP_VAL_LSB +: VW] = stored_value_in;
      rsp_tdata_in[bpbc_pkg::RSP_BUSY_BIT]      = pulses_left_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bpbc_pkg::MODE_BLINK;
      end else if (csr_wen) begin
         mode_ff <= bpbc_pkg::mode_type'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_counter_ff    <= '0;
         latched_duration_ff <= '0;
         prev_button_ff      <= 1'b1;
         pulses_left_ff      <= '0;
         half_period_ff      <= '0;
         phase_timer_ff      <= '0;
         led_phase_ff        <= 1'b0;
         stored_value_ff     <= '0;
         single_pulse_ff     <= 1'b0;
      end else if (req_accept) begin
         press_counter_ff    <= press_counter_in;
         latched_duration_ff <= latched_duration_in;
         prev_button_ff      <= prev_button_in;
         pulses_left_ff      <= pulses_left_in;
         half_period_ff      <= half_period_in;
         phase_timer_ff      <= phase_timer_in;
         led_phase_ff        <= led_phase_in;
         stored_value_ff     <= stored_value_in;
         single_pulse_ff     <= single_pulse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

/* hdl/bpbc_checker.sv */
// ---------------------------------------------------------------------------
// Button press blink coder checker
// Port-level assertions on the request/response streams of the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bpbc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [bpbc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // A stalled response item keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response item changed");

   // Every accepted tick yields a response item on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      !reset && req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no response");

   // A held response must block new ticks, otherwise one would be lost.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted over a stalled response");

   // The stored value is a 16-bit duration over 100 and its padding is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[bpbc_pkg::RSP_VAL_LSB +: bpbc_pkg::VALUE_W]
                        <= bpbc_pkg::VALUE_MAX
                     && rsp_tdata[bpbc_pkg::RSP_DATA_W-1:bpbc_pkg::RSP_USED_W] == '0)
      else $error("response value field out of range");

endmodule

bind button_press_blink_coder_top bpbc_checker u_bpbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* bench/button_press_blink_coder_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Press length coder checker
// Watches the request, response and register ports of the press length
// coder, works out the LED level and status that every tick should leave
// behind, and compares each response with the oldest outstanding tick.
// ---------------------------------------------------------------------------
module button_press_blink_coder_checker #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // req_tdata: [0] button_level, [7:1] zero
   input  wire logic [bpbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // rsp_tdata: [0] led_on, [16:1] last_duration_ms, [26:17] adjusted_value,
   // [27] pattern_busy, [31:28] zero
   input  wire logic [bpbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [1:0]                        csr_wdata,
   output int                                     errors,
   output int                                     pending,
   output logic                                   pattern_busy,
   output int                                     results_checked,
   output int                                     presses_released,
   output int                                     patterns_started,
   output logic [3:0]                             modes_released
);

   localparam int DUR_W    = bpbc_pkg::DUR_W;
   localparam int VALUE_W  = bpbc_pkg::VALUE_W;
   localparam int PULSES_W = bpbc_pkg::PULSES_W;
   localparam int HALF_W   = bpbc_pkg::HALF_W;

   localparam int BLINK_STEP_MS = 500;
   localparam int VALUE_STEP_MS = 100;

   typedef struct packed {
      logic               led;
      logic [DUR_W-1:0]   duration;
      logic [VALUE_W-1:0] value;
      logic               busy;
   } tick_status_type;

   // Status expected after each accepted tick, oldest first.
   tick_status_type awaited_status [$];

   bpbc_pkg::mode_type     mode_reg;
   logic [COUNT_WIDTH-1:0] press_len;
   logic [DUR_W-1:0]       held_duration;
   logic                   button_was_high;
   logic [PULSES_W-1:0]    pulses_to_go;
   logic [HALF_W-1:0]      half_len;
   logic [HALF_W-1:0]      half_timer;
   logic                   lit_half;
   logic [VALUE_W-1:0]     value_reg;
   logic                   one_shot;

   initial begin
      errors           = 0;
      pending          = 0;
      pattern_busy     = 1'b0;
      results_checked  = 0;
      presses_released = 0;
      patterns_started = 0;
      modes_released   = '0;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (errors < 100)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   function automatic void start_blinks(input logic [PULSES_W-1:0] pulses,
                                        input logic [HALF_W-1:0] half,
                                        input logic single);
      pulses_to_go = pulses;
      half_len     = half;
      half_timer   = half;
      lit_half     = (pulses != '0);
      one_shot     = single;
      if (pulses != '0)
         patterns_started++;
   endfunction

   function automatic void latch_release();
      logic [31:0]      wide;
      logic [DUR_W-1:0] d;
      wide = 32'(press_len);
      d = (wide > 32'(bpbc_pkg::DUR_MAX)) ? bpbc_pkg::DUR_MAX : DUR_W'(wide);
      held_duration = d;
      presses_released++;
      modes_released[mode_reg] = 1'b1;
      case (mode_reg)
         bpbc_pkg::MODE_BLINK: begin
            start_blinks(PULSES_W'(d / BLINK_STEP_MS), bpbc_pkg::HALF_BLINK, 1'b0);
         end
         bpbc_pkg::MODE_LEVEL: begin
            if (d < bpbc_pkg::DUR_1000)
               start_blinks(bpbc_pkg::PULSES_ONE, bpbc_pkg::HALF_SINGLE, 1'b1);
            else
               start_blinks(bpbc_pkg::PULSES_THREE, bpbc_pkg::HALF_TRIPLE, 1'b0);
         end
         bpbc_pkg::MODE_VALUE: begin
            value_reg = VALUE_W'(d / VALUE_STEP_MS);
         end
         default: begin
            if (d < bpbc_pkg::DUR_1000)
               start_blinks(bpbc_pkg::PULSES_ONE, bpbc_pkg::HALF_SHORT, 1'b1);
            else if (d < bpbc_pkg::DUR_3000)
               start_blinks(bpbc_pkg::PULSES_TWO, bpbc_pkg::HALF_DOUBLE, 1'b0);
            else
               start_blinks(bpbc_pkg::PULSES_FIVE, bpbc_pkg::HALF_SHORT, 1'b0);
         end
      endcase
   endfunction

   // One tick of a playing pattern. A single pulse ends as its lit half
   // ends; a blink sequence ends as the dark half of its last pulse ends.
   function automatic void step_pattern();
      if (half_timer != '0)
         half_timer--;
      if (half_timer == '0) begin
         if (lit_half) begin
            lit_half = 1'b0;
            if (one_shot && pulses_to_go == bpbc_pkg::PULSES_ONE)
               pulses_to_go = '0;
            else
               half_timer = half_len;
         end else begin
            pulses_to_go--;
            if (pulses_to_go != '0) begin
               lit_half   = 1'b1;
               half_timer = half_len;
            end
         end
      end
   endfunction

   function automatic tick_status_type tick_outcome(input logic level);
      tick_status_type st;
      if (pulses_to_go != '0) begin
         step_pattern();
      end else if (!level) begin
         if (button_was_high)
            press_len = COUNT_WIDTH'(1);
         else if (press_len != {COUNT_WIDTH{1'b1}})
            press_len++;
         button_was_high = 1'b0;
      end else begin
         if (!button_was_high)
            latch_release();
         button_was_high = 1'b1;
      end
      st.led      = !button_was_high ? 1'b1 : ((pulses_to_go != '0) ? lit_half : 1'b0);
      st.duration = held_duration;
      st.value    = value_reg;
      st.busy     = (pulses_to_go != '0);
      return st;
   endfunction

   always @(posedge clock) begin : watch
      tick_status_type got;
      tick_status_type want;
      if (reset) begin
         mode_reg        = bpbc_pkg::MODE_BLINK;
         press_len       = '0;
         held_duration   = '0;
         button_was_high = 1'b1;
         pulses_to_go    = '0;
         half_len        = '0;
         half_timer      = '0;
         lit_half        = 1'b0;
         value_reg       = '0;
         one_shot        = 1'b0;
         awaited_status.delete();
      end else begin
         // A response accepted at this edge belongs to an earlier tick, so
         // it is compared before this edge's tick is predicted.
         if (rsp_tvalid && rsp_tready) begin
            got.led      = rsp_tdata[bpbc_pkg::RSP_LED_BIT];
            got.duration = rsp_tdata[bpbc_pkg::RSP_DUR_LSB +: DUR_W];
            got.value    = rsp_tdata[bpbc_pkg::RSP_VAL_LSB +: VALUE_W];
            got.busy     = rsp_tdata[bpbc_pkg::RSP_BUSY_BIT];
            if (awaited_status.size() == 0) begin
               report_mismatch("response item with no tick outstanding", rsp_tdata, 0);
            end else begin
               want = awaited_status.pop_front();
               results_checked++;
               if (got.led !== want.led)
                  report_mismatch("led_on", got.led, want.led);
               if (got.duration !== want.duration)
                  report_mismatch("last_duration_ms", got.duration, want.duration);
               if (got.value !== want.value)
                  report_mismatch("adjusted_value", got.value, want.value);
               if (got.busy !== want.busy)
                  report_mismatch("pattern_busy", got.busy, want.busy);
            end
         end
         if (req_tvalid && req_tready)
            awaited_status.push_back(tick_outcome(req_tdata[0]));
         // A mode written at this edge only affects later ticks.
         if (csr_wen)
            mode_reg = bpbc_pkg::mode_type'(csr_wdata);
      end
      pending      <= awaited_status.size();
      pattern_busy <= (pulses_to_go != '0);
   end

endmodule

/* bench/button_press_blink_coder_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Press length coder testbench
// Drives button ticks into the press length coder with random gaps and
// back-pressure, steps through every mode with presses at the decision
// lengths and at saturation, then plays random presses; the checker beside
// the block predicts and compares every response item.
// ---------------------------------------------------------------------------
module button_press_blink_coder_top_tb;

   localparam int     COUNT_WIDTH    = 16;
   localparam int     REQ_W          = bpbc_pkg::REQ_DATA_W;
   localparam int     RSP_W          = bpbc_pkg::RSP_DATA_W;
   localparam int     RANDOM_PRESSES = 48;
   localparam int     HOLD_CYCLES    = 200;
   localparam int     DRAIN_CYCLES   = 20;
   localparam longint TIMEOUT_NS     = 64'd300_000_000;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [1:0]            csr_wdata  = '0;

   int                    errors;
   int                    pending;
   logic                  pattern_busy;
   int                    results_checked;
   int                    presses_released;
   int                    patterns_started;
   logic [3:0]            modes_released;

   int                    ticks_sent = 0;
   int                    tx_calm    = 0;
   int                    rx_calm    = 0;
   logic                  hold_req   = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   button_press_blink_coder_top #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   button_press_blink_coder_checker #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) chk (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_wen          (csr_wen),
      .csr_wdata        (csr_wdata),
      .errors           (errors),
      .pending          (pending),
      .pattern_busy     (pattern_busy),
      .results_checked  (results_checked),
      .presses_released (presses_released),
      .patterns_started (patterns_started),
      .modes_released   (modes_released)
   );

   // Gap before the next item: now and then a calm stretch with no gaps.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0)
         calm_left = $urandom_range(50, 800);
      return $urandom_range(0, 10);
   endfunction

   task automatic send_tick(input logic level);
      int gap;
      gap = draw_gap(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(level);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      ticks_sent++;
   endtask

   // Stops offering items and waits until every response has come back.
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic write_mode(input bpbc_pkg::mode_type m);
      pause_until_drained();
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // A press of len ticks, optionally a release followed by the button held
   // into the pattern, then released ticks until no pattern is playing.
   // With noisy set, ticks sent while a pattern plays carry random levels.
   task automatic play_press(input int len, input int held_after, input bit noisy);
      logic lvl;
      repeat (len) send_tick(1'b0);
      if (held_after > 0) begin
         send_tick(1'b1);
         repeat (held_after) send_tick(1'b0);
      end
      lvl = 1'b1;
      send_tick(1'b1);
      while (pattern_busy || !lvl) begin
         lvl = (noisy && pattern_busy) ? 1'($urandom_range(0, 1)) : 1'b1;
         send_tick(lvl);
      end
   endtask

   initial begin : receiver
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_req) begin
            // Long hold-off: the block fills up and must stall its input.
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            gap = draw_gap(rx_calm);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int pick;
      int len;
      int held;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Released ticks straight after reset show the reset status.
      repeat (3) send_tick(1'b1);

      write_mode(bpbc_pkg::MODE_BLINK);
      play_press(1, 0, 1'b0);
      play_press(499, 0, 1'b0);
      play_press(500, 0, 1'b1);
      play_press(1499, 0, 1'b0);

      write_mode(bpbc_pkg::MODE_LEVEL);
      hold_req = 1'b1;
      play_press(999, 0, 1'b0);
      play_press(1000, 0, 1'b1);

      // The last press runs well past the point where the count saturates.
      write_mode(bpbc_pkg::MODE_VALUE);
      play_press(99, 0, 1'b0);
      play_press(100, 0, 1'b0);
      play_press(70000, 0, 1'b0);

      write_mode(bpbc_pkg::MODE_MULTI);
      play_press(999, 0, 1'b0);
      play_press(1000, 0, 1'b0);
      play_press(2999, 0, 1'b0);
      play_press(3000, 0, 1'b1);
      // Button pressed again during a pulse and still held when it ends.
      play_press(200, 150, 1'b0);
      pause_until_drained();

      for (int n = 0; n < RANDOM_PRESSES; n++) begin
         if ($urandom_range(0, 5) == 0)
            write_mode(bpbc_pkg::mode_type'($urandom_range(0, 3)));
         else if ($urandom_range(0, 11) == 0)
            pause_until_drained();
         if ($urandom_range(0, 19) == 0)
            hold_req = 1'b1;
         // Occasional bouncing levels ahead of the real press.
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 30)) send_tick(1'($urandom_range(0, 1)));
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            len = $urandom_range(1, 20);
         end else if (pick < 45) begin
            len = $urandom_range(21, 999);
         end else if (pick < 75) begin
            len = $urandom_range(1000, 2999);
         end else if (pick < 88) begin
            len = $urandom_range(3000, 4200);
         end else begin
            case ($urandom_range(0, 3))
               0: len = 99 + $urandom_range(0, 1);
               1: len = 499 + $urandom_range(0, 1);
               2: len = 999 + $urandom_range(0, 1);
               default: len = 2999 + $urandom_range(0, 1);
            endcase
         end
         held = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 400) : 0;
         play_press(len, held, 1'($urandom_range(0, 1)));
      end

      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d ticks and %0d compared responses, with %0d presses",
               ticks_sent, results_checked, presses_released);
      $display("released (modes seen %b) and %0d LED patterns started.",
               modes_released, patterns_started);
      if (errors == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timed out with %0d responses outstanding.", pending);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/bpbc_pkg.sv
hdl/button_press_blink_coder_top.sv
hdl/bpbc_checker.sv
bench/button_press_blink_coder_checker.sv
bench/button_press_blink_coder_top_tb.sv
